// File: hdl/sw7seg_pkg.sv
// Shared types, constants and helper functions for the stopwatch display block.
`default_nettype none

package sw7seg_pkg;

  // Field widths
  localparam int unsigned DEB_W   = 4;
  localparam int unsigned LIM_W   = 6;
  localparam int unsigned MIN_W   = 7;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned SEG_W   = 7;
  localparam int unsigned APB_AW  = 4;
  localparam int unsigned APB_DW  = 32;

  // Counter limits
  localparam logic [MIN_W-1:0] MINUTE_MAX = 7'd99;
  localparam logic [LIM_W-1:0] COUNT_SAT  = 6'd63;
  localparam logic [DEB_W-1:0] PRESS_SAT  = 4'd15;

  // Register reset values
  localparam logic [DEB_W-1:0] DEBOUNCE_RST  = 4'd5;
  localparam logic [LIM_W-1:0] SUB_LIMIT_RST = 6'd59;
  localparam logic [LIM_W-1:0] SEC_LIMIT_RST = 6'd59;

  // All segments off
  localparam logic [SEG_W-1:0] SEG_BLANK = 7'h7f;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_SUB_LIMIT = 2'd1,
    REG_SEC_LIMIT = 2'd2
  } reg_idx_t;

  // Tick kind
  typedef enum logic {
    OP_COUNT   = 1'b0,
    OP_DISPLAY = 1'b1
  } op_t;

  typedef struct packed {
    logic [DEB_W-1:0] debounce_ticks;
    logic [LIM_W-1:0] subsecond_limit;
    logic [LIM_W-1:0] second_limit;
  } cfg_t;

  typedef struct packed {
    logic [SEG_W-1:0]   segments_n;
    logic [PHASE_W-1:0] digit_index;
    logic               led_on;
    logic               is_paused;
    logic [LIM_W-1:0]   subsecond_count;
    logic [LIM_W-1:0]   second_count;
    logic [MIN_W-1:0]   minute_count;
    logic               minutes_mode;
  } result_t;

  // Active-low pattern, bit0 = a .. bit6 = g; codes above nine are blank
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] pat;
    case (digit)
      4'd0:    pat = 7'h40;
      4'd1:    pat = 7'h79;
      4'd2:    pat = 7'h24;
      4'd3:    pat = 7'h30;
      4'd4:    pat = 7'h19;
      4'd5:    pat = 7'h12;
      4'd6:    pat = 7'h02;
      4'd7:    pat = 7'h78;
      4'd8:    pat = 7'h00;
      4'd9:    pat = 7'h10;
      default: pat = SEG_BLANK;
    endcase
    return pat;
  endfunction

  // Quotient by ten through a reciprocal multiply; exact for values up to 127
  function automatic logic [DIGIT_W-1:0] div10(input logic [MIN_W-1:0] val);
    logic [14:0] prod;
    prod = {8'd0, val} * 15'd205;
    return prod[14:11];
  endfunction

endpackage

`default_nettype wire

// File: hdl/sw7seg_cfg.sv
// APB register file for debounce length and rollover limits.
`default_nettype none

module sw7seg_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [sw7seg_pkg::APB_AW-1:0]   paddr,
  input  wire logic [sw7seg_pkg::APB_DW-1:0]   pwdata,
  output      logic [sw7seg_pkg::APB_DW-1:0]   prdata,
  output      logic                            pready,
  output      sw7seg_pkg::cfg_t                cfg
);

  sw7seg_pkg::cfg_t cfg_r;
  sw7seg_pkg::reg_idx_t idx;
  logic wr_en;

  assign pready = 1'b1;
  assign idx    = sw7seg_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  // Write on the access phase; unknown addresses are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks  <= sw7seg_pkg::DEBOUNCE_RST;
      cfg_r.subsecond_limit <= sw7seg_pkg::SUB_LIMIT_RST;
      cfg_r.second_limit    <= sw7seg_pkg::SEC_LIMIT_RST;
    end else if (wr_en) begin
      unique case (idx)
        sw7seg_pkg::REG_DEBOUNCE:
          cfg_r.debounce_ticks <= pwdata[sw7seg_pkg::DEB_W-1:0];
        sw7seg_pkg::REG_SUB_LIMIT:
          cfg_r.subsecond_limit <= pwdata[sw7seg_pkg::LIM_W-1:0];
        sw7seg_pkg::REG_SEC_LIMIT:
          cfg_r.second_limit <= pwdata[sw7seg_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, zero extended
  always_comb begin
    prdata = '0;
    unique case (idx)
      sw7seg_pkg::REG_DEBOUNCE:
        prdata = {{(sw7seg_pkg::APB_DW-sw7seg_pkg::DEB_W){1'b0}}, cfg_r.debounce_ticks};
      sw7seg_pkg::REG_SUB_LIMIT:
        prdata = {{(sw7seg_pkg::APB_DW-sw7seg_pkg::LIM_W){1'b0}}, cfg_r.subsecond_limit};
      sw7seg_pkg::REG_SEC_LIMIT:
        prdata = {{(sw7seg_pkg::APB_DW-sw7seg_pkg::LIM_W){1'b0}}, cfg_r.second_limit};
      default: prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/sw7seg_core.sv
// Stopwatch state and the single-pass tick update that forms each result.
`default_nettype none

module sw7seg_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic               op,
  input  wire logic               pause_n,
  input  wire logic               reset_n,
  input  wire sw7seg_pkg::cfg_t   cfg,
  output      sw7seg_pkg::result_t res
);

  logic [sw7seg_pkg::LIM_W-1:0]   subsec_r, subsec_nxt;
  logic [sw7seg_pkg::LIM_W-1:0]   sec_r, sec_nxt;
  logic [sw7seg_pkg::MIN_W-1:0]   min_r, min_nxt;
  logic                           mmode_r, mmode_nxt;
  logic [sw7seg_pkg::DEB_W-1:0]   press_cnt_r, press_cnt_nxt;
  logic                           armed_r, armed_nxt;
  logic                           paused_r, paused_nxt;
  logic                           led_r, led_nxt;
  logic [sw7seg_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [sw7seg_pkg::DIGIT_W-1:0] digit_r, digit_nxt;

  logic [sw7seg_pkg::LIM_W-1:0]   ss_roll, s_roll;
  logic [sw7seg_pkg::MIN_W-1:0]   m_roll;
  logic                           mm_roll;
  logic [sw7seg_pkg::MIN_W-1:0]   shown;
  logic [sw7seg_pkg::DIGIT_W-1:0] quot;
  logic [sw7seg_pkg::DIGIT_W-1:0] rem;
  logic                           any_press;
  logic                           clear_req;
  logic [sw7seg_pkg::SEG_W-1:0]   seg;

  // Rollover: sub-seconds into seconds, else seconds into minutes
  always_comb begin
    ss_roll = subsec_r;
    s_roll  = sec_r;
    m_roll  = min_r;
    mm_roll = mmode_r;
    if (subsec_r > cfg.subsecond_limit) begin
      if (sec_r < sw7seg_pkg::COUNT_SAT) begin
        s_roll = sec_r + 1'b1;
      end
      ss_roll = '0;
    end else if (sec_r > cfg.second_limit) begin
      m_roll  = (min_r >= sw7seg_pkg::MINUTE_MAX) ? '0 : min_r + 1'b1;
      s_roll  = '0;
      mm_roll = 1'b1;
    end
  end

  // Pick the digit for the current scan phase and split it by ten
  always_comb begin
    if (phase_r[1]) begin
      shown = mm_roll ? m_roll : {1'b0, s_roll};
    end else begin
      shown = mm_roll ? {1'b0, s_roll} : {1'b0, ss_roll};
    end
    quot = sw7seg_pkg::div10(shown);
    rem  = 4'(shown - ({3'b0, quot} * 7'd10));
  end

  // Apply the tick on top of the rolled-over state
  always_comb begin
    subsec_nxt    = ss_roll;
    sec_nxt       = s_roll;
    min_nxt       = m_roll;
    mmode_nxt     = mm_roll;
    press_cnt_nxt = press_cnt_r;
    armed_nxt     = armed_r;
    paused_nxt    = paused_r;
    led_nxt       = led_r;
    phase_nxt     = phase_r;
    digit_nxt     = digit_r;
    seg           = sw7seg_pkg::SEG_BLANK;
    any_press     = ~pause_n | ~reset_n;
    clear_req     = 1'b0;

    if (op == sw7seg_pkg::OP_DISPLAY) begin
      seg       = sw7seg_pkg::seg_pattern(digit_r);
      phase_nxt = phase_r + 1'b1;
      digit_nxt = phase_r[0] ? rem : quot;
    end else begin
      // Debounce the buttons
      if (any_press) begin
        if (armed_r && press_cnt_r == cfg.debounce_ticks) begin
          if (!pause_n) begin
            led_nxt    = ~led_nxt;
            paused_nxt = ~paused_nxt;
          end
          if (!reset_n) begin
            led_nxt   = ~led_nxt;
            clear_req = 1'b1;
          end
        end else if (!armed_r) begin
          armed_nxt     = 1'b1;
          press_cnt_nxt = '0;
        end
      end else begin
        armed_nxt = 1'b0;
      end
      if (press_cnt_nxt < sw7seg_pkg::PRESS_SAT) begin
        press_cnt_nxt = press_cnt_nxt + 1'b1;
      end
      // Count unless paused
      if (!paused_nxt && ss_roll < sw7seg_pkg::COUNT_SAT) begin
        subsec_nxt = ss_roll + 1'b1;
      end
      if (clear_req) begin
        subsec_nxt = '0;
        sec_nxt    = '0;
        min_nxt    = '0;
        mmode_nxt  = 1'b0;
        paused_nxt = ~paused_nxt;
      end
    end
  end

  // Result fields from the updated state
  always_comb begin
    res.segments_n      = seg;
    res.digit_index     = phase_nxt;
    res.led_on          = led_nxt;
    res.is_paused       = paused_nxt;
    res.subsecond_count = subsec_nxt;
    res.second_count    = sec_nxt;
    res.minute_count    = min_nxt;
    res.minutes_mode    = mmode_nxt;
  end

  // Commit state on each processed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subsec_r    <= '0;
      sec_r       <= '0;
      min_r       <= '0;
      mmode_r     <= 1'b0;
      press_cnt_r <= '0;
      armed_r     <= 1'b0;
      paused_r    <= 1'b0;
      led_r       <= 1'b0;
      phase_r     <= '0;
      digit_r     <= '0;
    end else if (step) begin
      subsec_r    <= subsec_nxt;
      sec_r       <= sec_nxt;
      min_r       <= min_nxt;
      mmode_r     <= mmode_nxt;
      press_cnt_r <= press_cnt_nxt;
      armed_r     <= armed_nxt;
      paused_r    <= paused_nxt;
      led_r       <= led_nxt;
      phase_r     <= phase_nxt;
      digit_r     <= digit_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/stopwatch_seven_segment.sv
// Top level: input register, tick update core, result register and APB registers.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | operation, pause_button_n, reset_button_n
//   out_    | output    | out_valid/out_stall | segments_n .. minutes_mode
//   APB     | input     | psel/penable/pready | debounce_ticks, subsecond_limit, second_limit
//
// One tick per cycle is sustained while out_stall is low; each tick passes the input register
// and then the result register, and its result is presented from the result register.
// The update of all counters and the digit split by ten is one combinational pass.
// Reset (rst_n low, synchronous) clears all counters, flags and scan state and
// restores the register defaults.
// A stalled result holds; the input register keeps taking ticks until it is also full.

`default_nettype none

module stopwatch_seven_segment (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // tick input
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire logic                               in_operation,
  input  wire logic                               in_pause_button_n,
  input  wire logic                               in_reset_button_n,
  // result output
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      logic [sw7seg_pkg::SEG_W-1:0]       out_segments_n,
  output      logic [sw7seg_pkg::PHASE_W-1:0]     out_digit_index,
  output      logic                               out_led_on,
  output      logic                               out_is_paused,
  output      logic [sw7seg_pkg::LIM_W-1:0]       out_subsecond_count,
  output      logic [sw7seg_pkg::LIM_W-1:0]       out_second_count,
  output      logic [sw7seg_pkg::MIN_W-1:0]       out_minute_count,
  output      logic                               out_minutes_mode,
  // configuration
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [sw7seg_pkg::APB_AW-1:0]      paddr,
  input  wire logic [sw7seg_pkg::APB_DW-1:0]      pwdata,
  output      logic [sw7seg_pkg::APB_DW-1:0]      prdata,
  output      logic                               pready
);

  logic                in_valid_r;
  logic                op_r;
  logic                pause_n_r;
  logic                reset_n_r;
  logic                out_valid_r;
  sw7seg_pkg::result_t res_r;
  sw7seg_pkg::result_t res_nxt;
  sw7seg_pkg::cfg_t    cfg;
  logic                advance;
  logic                step;

  sw7seg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sw7seg_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .op      (op_r),
    .pause_n (pause_n_r),
    .reset_n (reset_n_r),
    .cfg     (cfg),
    .res     (res_nxt)
  );

  // Result register is free or drains this cycle
  assign advance  = ~out_valid_r | ~out_stall;
  assign step     = in_valid_r & advance;
  assign in_stall = in_valid_r & ~advance;

  // Input register: take a transfer, or drop the tick once processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r      <= in_operation;
      pause_n_r <= in_pause_button_n;
      reset_n_r <= in_reset_button_n;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_segments_n      = res_r.segments_n;
  assign out_digit_index     = res_r.digit_index;
  assign out_led_on          = res_r.led_on;
  assign out_is_paused       = res_r.is_paused;
  assign out_subsecond_count = res_r.subsecond_count;
  assign out_second_count    = res_r.second_count;
  assign out_minute_count    = res_r.minute_count;
  assign out_minutes_mode    = res_r.minutes_mode;

endmodule

`default_nettype wire
